### sv/assert_macros.svh
// Assertion helper macros for the 2D k-means clustering unit.
// Expects clk and rst_n in the scope of the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is held.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds across reset.
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/kmc_pkg.sv
// Shared types, constants and helpers for the 2D k-means clustering unit.
// No dependencies.
`default_nettype none

package kmc_pkg;

  localparam int COORD_W = 16;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  typedef enum logic [1:0] {
    CFG_CLUSTERS = 2'd0,
    CFG_MAX_ITER = 2'd1,
    CFG_SEED     = 2'd2
  } cfg_idx_t;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_QOUT  = 14'b00000000000010,
    S_ILFSR = 14'b00000000000100,
    S_IDIV  = 14'b00000000001000,
    S_IRD   = 14'b00000000010000,
    S_RND   = 14'b00000000100000,
    S_RD    = 14'b00000001000000,
    S_DIST  = 14'b00000010000000,
    S_ACC   = 14'b00000100000000,
    S_CHK   = 14'b00001000000000,
    S_UPD   = 14'b00010000000000,
    S_UDX   = 14'b00100000000000,
    S_UDY   = 14'b01000000000000,
    S_OUT   = 14'b10000000000000
  } state_t;

  // One step of the Galois LFSR.
  function automatic logic [15:0] lfsr_step(input logic [15:0] v);
    logic [15:0] s;
    s = {1'b0, v[15:1]};
    if (v[0]) begin
      s = s ^ LFSR_TAPS;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

### sv/kmeans_2d_clustering_unit.sv
// Top level of the 2D k-means clustering unit: point store, sequencer,
// shared multiplier and shared restoring divider. Depends on kmc_pkg, assert_macros.svh.
`default_nettype none

// Channel   Dir  Handshake            Moves
// in_       in   in_valid/in_stall    point load or label query
// out_      out  out_valid/out_stall  cluster summary or label answer
// cfg_      in   cfg_valid/cfg_ready  register index and write data
//
// Points and label queries are taken only in idle; a query answer waits for the output register.
// A run seeds the k means from LFSR-drawn points, then repeats an assign pass and a
// mean update; DW, the divider width, is 26 at the defaults. One shared multiplier
// and one shared divider serve all of them.
// Reset is synchronous, active low; the stores need no clearing pass.
// A stalled result holds in the output register; the sequencer waits on it.

module kmeans_2d_clustering_unit #(
  parameter int MAX_POINTS   = 1024,
  parameter int MAX_CLUSTERS = 16
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire                            in_mode,
  input  wire signed [kmc_pkg::COORD_W-1:0] in_point_x,
  input  wire signed [kmc_pkg::COORD_W-1:0] in_point_y,
  input  wire                            in_last_point,
  input  wire  [9:0]                     in_query_index,
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic                           out_kind,
  output logic [3:0]                     out_cluster_index,
  output logic signed [kmc_pkg::COORD_W-1:0] out_mean_x,
  output logic signed [kmc_pkg::COORD_W-1:0] out_mean_y,
  output logic [10:0]                    out_member_count,
  output logic [7:0]                     out_rounds,
  output logic                           out_converged,
  output logic                           out_last,
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire  [1:0]                     cfg_index,
  input  wire  [15:0]                    cfg_data
);
  import kmc_pkg::*;

  `include "assert_macros.svh"

  localparam int PW   = $clog2(MAX_POINTS);
  localparam int NW   = PW + 1;
  localparam int CW   = $clog2(MAX_CLUSTERS);
  localparam int KW   = CW + 1;
  localparam int SUMW = COORD_W + PW;
  localparam int DW   = (SUMW > 16) ? SUMW : 16;
  localparam int DCW  = $clog2(DW);
  localparam int SQW  = 2 * COORD_W;
  localparam int DSW  = SQW + 1;

  // Configuration registers
  logic [4:0]  cc_r;
  logic [7:0]  maxit_r;
  logic [15:0] lfsr_r;

  state_t state_r;

  // Point and label stores
  logic signed [COORD_W-1:0] pts_x_mem [MAX_POINTS];
  logic signed [COORD_W-1:0] pts_y_mem [MAX_POINTS];
  logic [CW-1:0]             lab_mem   [MAX_POINTS];
  logic signed [COORD_W-1:0] rd_x_r, rd_y_r;
  logic [CW-1:0]             lab_rd_r;

  // Per-cluster registers
  logic signed [COORD_W-1:0] means_x_r [MAX_CLUSTERS];
  logic signed [COORD_W-1:0] means_y_r [MAX_CLUSTERS];
  logic signed [SUMW-1:0]    sums_x_r  [MAX_CLUSTERS];
  logic signed [SUMW-1:0]    sums_y_r  [MAX_CLUSTERS];
  logic [NW-1:0]             counts_r  [MAX_CLUSTERS];

  // Sequencer registers
  logic [NW-1:0] loaded_r, n_r;
  logic [KW-1:0] k_r;
  logic [7:0]    cap_r, rnd_r;
  logic [CW-1:0] j_r, best_j_r;
  logic [PW-1:0] i_r;
  logic [1:0]    ph_r;
  logic          changed_r, conv_r, q_oor_r;
  logic [SQW-1:0] sq_r, dx2_r;
  logic [DSW-1:0] best_r;

  // Shared divider
  logic          div_busy_r, div_done_r, div_neg_r;
  logic [DW-1:0] div_q_r;
  logic [NW-1:0] div_rem_r, div_den_r;
  logic [DCW-1:0] div_cnt_r;
  logic          div_start;
  logic [DW-1:0] div_num_in;
  logic [NW-1:0] div_den_in;
  logic          div_neg_in;
  logic [NW:0]   div_sh;
  logic          div_ge;

  // Output register
  logic        out_valid_r;
  logic        out_free;
  logic        out_load;

  // Combinational helpers
  logic          in_acc;
  logic [15:0]   lfsr_nxt;
  logic          pt_rd_en;
  logic [PW-1:0] pt_rd_addr;
  logic          lab_rd_en;
  logic [PW-1:0] lab_rd_addr;
  logic [KW-1:0] k_eff;
  logic signed [COORD_W:0] diff;
  logic [COORD_W-1:0] mul_a;
  logic [SQW-1:0]     mul_p;
  logic [DSW-1:0]     dist_sum;
  logic [CW-1:0]      sum_sel;
  logic signed [SUMW-1:0] sum_x_sel, sum_y_sel;
  logic [SUMW-1:0]    sum_mag;
  logic signed [COORD_W-1:0] div_mean;
  logic [CW-1:0]      k_last;
  logic               j_is_last;
  logic               pt_store;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;
  // Load a new result whenever a reporting state finds the register free
  assign out_load  = ((state_r == S_QOUT) || (state_r == S_OUT)) && out_free;
  assign lfsr_nxt  = lfsr_step(lfsr_r);
  assign k_last    = CW'(k_r - KW'(1));
  assign j_is_last = (j_r == k_last);
  assign pt_store  = (loaded_r < NW'(MAX_POINTS));

  always_comb begin
    if (cc_r == 5'd0) begin
      k_eff = KW'(1);
    end else if (32'(cc_r) > MAX_CLUSTERS) begin
      k_eff = KW'(MAX_CLUSTERS);
    end else begin
      k_eff = KW'(cc_r);
    end
  end

  // Point store read: the init draw or the assign pass
  assign pt_rd_en   = ((state_r == S_IDIV) && div_done_r) || (state_r == S_RD);
  assign pt_rd_addr = (state_r == S_RD) ? i_r : PW'(div_rem_r);
  assign lab_rd_en  = (in_acc && in_mode) || (state_r == S_RD);
  assign lab_rd_addr = (state_r == S_RD) ? i_r : PW'(in_query_index);

  always_ff @(posedge clk) begin
    if (in_acc && !in_mode && pt_store) begin
      pts_x_mem[PW'(loaded_r)] <= in_point_x;
      pts_y_mem[PW'(loaded_r)] <= in_point_y;
    end
    if (pt_rd_en) begin
      rd_x_r <= pts_x_mem[pt_rd_addr];
      rd_y_r <= pts_y_mem[pt_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_ACC) begin
      lab_mem[i_r] <= best_j_r;
    end
    if (lab_rd_en) begin
      lab_rd_r <= lab_mem[lab_rd_addr];
    end
  end

  // Shared squarer: x difference in phase 0, y difference in phase 1
  always_comb begin
    if (ph_r == 2'd0) begin
      diff = {rd_x_r[COORD_W-1], rd_x_r} - {means_x_r[j_r][COORD_W-1], means_x_r[j_r]};
    end else begin
      diff = {rd_y_r[COORD_W-1], rd_y_r} - {means_y_r[j_r][COORD_W-1], means_y_r[j_r]};
    end
    mul_a = diff[COORD_W] ? COORD_W'(-diff) : COORD_W'(diff);
  end
  assign mul_p    = mul_a * mul_a;
  assign dist_sum = DSW'(dx2_r) + DSW'(sq_r);

  // Sum select: accumulate at the best cluster, divide at cluster j
  assign sum_sel   = (state_r == S_ACC) ? best_j_r : j_r;
  assign sum_x_sel = sums_x_r[sum_sel];
  assign sum_y_sel = sums_y_r[sum_sel];

  always_comb begin
    div_start  = 1'b0;
    div_num_in = DW'(lfsr_nxt);
    div_den_in = n_r;
    div_neg_in = 1'b0;
    sum_mag    = sum_x_sel[SUMW-1] ? SUMW'(~sum_x_sel + 1'b1) : SUMW'(sum_x_sel);
    if (state_r == S_ILFSR) begin
      div_start = 1'b1;
    end else if ((state_r == S_UPD) && (counts_r[j_r] != '0)) begin
      div_start  = 1'b1;
      div_num_in = DW'(sum_mag);
      div_den_in = counts_r[j_r];
      div_neg_in = sum_x_sel[SUMW-1];
    end else if ((state_r == S_UDX) && div_done_r) begin
      sum_mag    = sum_y_sel[SUMW-1] ? SUMW'(~sum_y_sel + 1'b1) : SUMW'(sum_y_sel);
      div_start  = 1'b1;
      div_num_in = DW'(sum_mag);
      div_den_in = counts_r[j_r];
      div_neg_in = sum_y_sel[SUMW-1];
    end
  end

  // Restoring divider, one quotient bit per cycle
  assign div_sh   = {div_rem_r, div_q_r[DW-1]};
  assign div_ge   = (div_sh >= {1'b0, div_den_r});
  assign div_mean = div_neg_r ? COORD_W'(-div_q_r) : COORD_W'(div_q_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      div_done_r <= 1'b0;
    end else begin
      div_done_r <= 1'b0;
      if (div_start) begin
        div_busy_r <= 1'b1;
        div_cnt_r  <= '0;
        div_q_r    <= div_num_in;
        div_rem_r  <= '0;
        div_den_r  <= div_den_in;
        div_neg_r  <= div_neg_in;
      end else if (div_busy_r) begin
        div_rem_r <= div_ge ? NW'(div_sh - {1'b0, div_den_r}) : NW'(div_sh);
        div_q_r   <= {div_q_r[DW-2:0], div_ge};
        div_cnt_r <= div_cnt_r + 1'b1;
        if (div_cnt_r == DCW'(DW - 1)) begin
          div_busy_r <= 1'b0;
          div_done_r <= 1'b1;
        end
      end
    end
  end

  // Configuration writes; seed goes straight into the LFSR
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r    <= 5'd2;
      maxit_r <= 8'd64;
      lfsr_r  <= 16'd1;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_CLUSTERS: cc_r    <= cfg_data[4:0];
          CFG_MAX_ITER: maxit_r <= cfg_data[7:0];
          CFG_SEED:     lfsr_r  <= (cfg_data == 16'd0) ? 16'd1 : cfg_data;
          default: ;
        endcase
      end
      if (state_r == S_ILFSR) begin
        lfsr_r <= lfsr_nxt;
      end
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      loaded_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_mode) begin
              q_oor_r <= (32'(in_query_index) >= MAX_POINTS);
              state_r <= S_QOUT;
            end else if (in_last_point) begin
              n_r      <= pt_store ? loaded_r + 1'b1 : loaded_r;
              loaded_r <= '0;
              k_r      <= k_eff;
              cap_r    <= (maxit_r == 8'd0) ? 8'd1 : maxit_r;
              j_r      <= '0;
              rnd_r    <= '0;
              state_r  <= S_ILFSR;
            end else if (pt_store) begin
              loaded_r <= loaded_r + 1'b1;
            end
          end
        end
        S_QOUT: begin
          if (out_free) begin
            out_kind          <= 1'b1;
            out_cluster_index <= q_oor_r ? 4'd0 : 4'(lab_rd_r);
            out_mean_x        <= '0;
            out_mean_y        <= '0;
            out_member_count  <= '0;
            out_rounds        <= '0;
            out_converged     <= 1'b0;
            out_last          <= 1'b1;
            state_r           <= S_IDLE;
          end
        end
        S_ILFSR: state_r <= S_IDIV;
        S_IDIV: begin
          if (div_done_r) begin
            state_r <= S_IRD;
          end
        end
        S_IRD: begin
          means_x_r[j_r] <= rd_x_r;
          means_y_r[j_r] <= rd_y_r;
          if (j_is_last) begin
            state_r <= S_RND;
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= S_ILFSR;
          end
        end
        S_RND: begin
          for (int c = 0; c < MAX_CLUSTERS; c++) begin
            sums_x_r[c] <= '0;
            sums_y_r[c] <= '0;
            counts_r[c] <= '0;
          end
          changed_r <= (rnd_r == 8'd0);
          rnd_r     <= rnd_r + 1'b1;
          i_r       <= '0;
          state_r   <= S_RD;
        end
        S_RD: begin
          j_r     <= '0;
          ph_r    <= 2'd0;
          state_r <= S_DIST;
        end
        S_DIST: begin
          unique case (ph_r)
            2'd0: begin
              sq_r <= mul_p;
              ph_r <= 2'd1;
            end
            2'd1: begin
              dx2_r <= sq_r;
              sq_r  <= mul_p;
              ph_r  <= 2'd2;
            end
            default: begin
              if ((j_r == '0) || (dist_sum < best_r)) begin
                best_r   <= dist_sum;
                best_j_r <= j_r;
              end
              ph_r <= 2'd0;
              if (j_is_last) begin
                state_r <= S_ACC;
              end else begin
                j_r <= j_r + 1'b1;
              end
            end
          endcase
        end
        S_ACC: begin
          if (lab_rd_r != best_j_r) begin
            changed_r <= 1'b1;
          end
          sums_x_r[best_j_r] <= sum_x_sel + SUMW'(rd_x_r);
          sums_y_r[best_j_r] <= sum_y_sel + SUMW'(rd_y_r);
          counts_r[best_j_r] <= counts_r[best_j_r] + 1'b1;
          if (i_r == PW'(n_r - 1'b1)) begin
            state_r <= S_CHK;
          end else begin
            i_r     <= i_r + 1'b1;
            state_r <= S_RD;
          end
        end
        S_CHK: begin
          j_r <= '0;
          if (!changed_r) begin
            conv_r  <= 1'b1;
            state_r <= S_OUT;
          end else begin
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          if (counts_r[j_r] != '0) begin
            state_r <= S_UDX;
          end else if (j_is_last) begin
            j_r <= '0;
            if (rnd_r == cap_r) begin
              conv_r  <= 1'b0;
              state_r <= S_OUT;
            end else begin
              state_r <= S_RND;
            end
          end else begin
            j_r <= j_r + 1'b1;
          end
        end
        S_UDX: begin
          if (div_done_r) begin
            means_x_r[j_r] <= div_mean;
            state_r        <= S_UDY;
          end
        end
        S_UDY: begin
          if (div_done_r) begin
            means_y_r[j_r] <= div_mean;
            if (j_is_last) begin
              j_r <= '0;
              if (rnd_r == cap_r) begin
                conv_r  <= 1'b0;
                state_r <= S_OUT;
              end else begin
                state_r <= S_RND;
              end
            end else begin
              j_r     <= j_r + 1'b1;
              state_r <= S_UPD;
            end
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_kind          <= 1'b0;
            out_cluster_index <= 4'(j_r);
            out_mean_x        <= means_x_r[j_r];
            out_mean_y        <= means_y_r[j_r];
            out_member_count  <= 11'(counts_r[j_r]);
            out_rounds        <= rnd_r;
            out_converged     <= conv_r;
            out_last          <= j_is_last;
            if (j_is_last) begin
              state_r <= S_IDLE;
            end else begin
              j_r <= j_r + 1'b1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Divider runs only when the sequencer waits on it
  `ASSERT_CLK(a_div_owner, div_busy_r |-> (state_r == S_IDIV || state_r == S_UDX || state_r == S_UDY), "divider busy outside a divide wait")
  // Last summary of a run carries cluster k-1
  `ASSERT_CLK(a_last_idx, (out_valid_r && !out_kind && out_last) |-> (out_cluster_index == 4'(k_r - KW'(1))), "last summary has wrong cluster index")
  // Reset drops any pending result
  `ASSERT_RST(a_rst_out, !rst_n |=> !out_valid_r, "result valid after reset")

endmodule

`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for kmeans_2d_clustering_unit: point loads, label reads and full
// clustering runs are checked against an in-bench predictor. Depends on kmc_pkg and kmeans_2d_clustering_unit.

module tb_top;
  import kmc_pkg::*;

  localparam int NUM_POINTS   = 1024;
  localparam int NUM_CLUSTERS = 16;
  localparam int RANDOM_ITEMS = 150;
  localparam int SETTLE_CYCLES = 60;
  localparam int STUCK_LIMIT  = 3000000;

  localparam bit MODE_LOAD  = 1'b0;
  localparam bit MODE_QUERY = 1'b1;
  localparam bit KIND_SUMMARY = 1'b0;
  localparam bit KIND_LABEL   = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [3:0]  cluster;
    logic [15:0] mean_x;
    logic [15:0] mean_y;
    logic [10:0] members;
    logic [7:0]  rounds;
    logic        converged;
    logic        last;
  } report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_mode = 1'b0;
  logic [15:0] in_point_x = '0;
  logic [15:0] in_point_y = '0;
  logic        in_last_point = 1'b0;
  logic [9:0]  in_query_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_kind;
  logic [3:0]  out_cluster_index;
  logic [15:0] out_mean_x;
  logic [15:0] out_mean_y;
  logic [10:0] out_member_count;
  logic [7:0]  out_rounds;
  logic        out_converged;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  always #2 clk = ~clk;

  kmeans_2d_clustering_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_mode(in_mode),
    .in_point_x(in_point_x), .in_point_y(in_point_y),
    .in_last_point(in_last_point), .in_query_index(in_query_index),
    .out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind),
    .out_cluster_index(out_cluster_index), .out_mean_x(out_mean_x),
    .out_mean_y(out_mean_y), .out_member_count(out_member_count),
    .out_rounds(out_rounds), .out_converged(out_converged), .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: its own copy of the point store, labels, means, LFSR and
  // the three registers; all but the means are kept at the block's widths.
  // ---------------------------------------------------------------------------
  logic signed [15:0] store_x [NUM_POINTS];
  logic signed [15:0] store_y [NUM_POINTS];
  logic [3:0]         store_label [NUM_POINTS];
  longint             cur_mean_x [NUM_CLUSTERS];
  longint             cur_mean_y [NUM_CLUSTERS];
  int                 fill_count;
  logic [15:0]        pick_lfsr;
  logic [4:0]         reg_clusters;
  logic [7:0]         reg_max_iter;
  logic [15:0]        reg_seed;
  int                 labeled_upto;  // labels below this index were written by a run

  report_t pending_reports[$];

  int mismatches;
  int runs_done;
  int points_loaded;
  int labels_read;
  int reports_checked;

  bit gaps_on;    // sender idles between transfers when set
  bit stalls_on;  // receiver stalls at random when set

  // One full clustering run (Lloyd rounds up to the cap) over the stored set; push one summary per cluster.
  task automatic predict_clustering();
    int n, k, cap, best, rounds_done;
    longint sum_x [NUM_CLUSTERS];
    longint sum_y [NUM_CLUSTERS];
    int members [NUM_CLUSTERS];
    longint dx, dy, d, best_d;
    bit changed, converged;
    report_t rep;
    n = fill_count;
    fill_count = 0;
    k = (reg_clusters == 0) ? 1 : ((reg_clusters > NUM_CLUSTERS) ? NUM_CLUSTERS : reg_clusters);
    cap = (reg_max_iter == 0) ? 1 : reg_max_iter;
    converged = 1'b0;
    rounds_done = 0;
    // Seed the means from points at LFSR-drawn indices; advance before each draw.
    for (int j = 0; j < k; j++) begin
      pick_lfsr = {1'b0, pick_lfsr[15:1]} ^ (pick_lfsr[0] ? 16'hB400 : 16'h0000);
      cur_mean_x[j] = store_x[int'(pick_lfsr) % n];
      cur_mean_y[j] = store_y[int'(pick_lfsr) % n];
    end
    for (int r = 1; r <= cap; r++) begin
      changed = (r == 1);
      for (int j = 0; j < k; j++) begin
        sum_x[j] = 0; sum_y[j] = 0; members[j] = 0;
      end
      for (int i = 0; i < n; i++) begin
        best = 0;
        best_d = 0;
        for (int j = 0; j < k; j++) begin
          dx = longint'(store_x[i]) - cur_mean_x[j];
          dy = longint'(store_y[i]) - cur_mean_y[j];
          d = dx * dx + dy * dy;
          // Strict compare keeps ties on the lower index.
          if (j == 0 || d < best_d) begin
            best_d = d;
            best = j;
          end
        end
        if (store_label[i] != best[3:0]) changed = 1'b1;
        store_label[i] = best[3:0];
        sum_x[best] += store_x[i];
        sum_y[best] += store_y[i];
        members[best]++;
      end
      rounds_done = r;
      if (!changed) begin
        converged = 1'b1;
        break;
      end
      // Empty clusters hold their old mean.
      for (int j = 0; j < k; j++) begin
        if (members[j] != 0) begin
          cur_mean_x[j] = sum_x[j] / members[j];
          cur_mean_y[j] = sum_y[j] / members[j];
        end
      end
    end
    if (n > labeled_upto) labeled_upto = n;
    for (int j = 0; j < k; j++) begin
      rep.kind = KIND_SUMMARY;
      rep.cluster = j[3:0];
      rep.mean_x = cur_mean_x[j][15:0];
      rep.mean_y = cur_mean_y[j][15:0];
      rep.members = members[j][10:0];
      rep.rounds = rounds_done[7:0];
      rep.converged = converged;
      rep.last = (j == k - 1);
      pending_reports.push_back(rep);
    end
    runs_done++;
  endtask

  // Update the predictor for one accepted input transfer.
  task automatic absorb_item(input bit mode, input logic [15:0] x, input logic [15:0] y,
                             input bit last_pt, input logic [9:0] q);
    report_t rep;
    if (mode == MODE_QUERY) begin
      rep = '0;
      rep.kind = KIND_LABEL;
      rep.cluster = store_label[q];
      rep.last = 1'b1;
      pending_reports.push_back(rep);
      labels_read++;
    end else begin
      // Drop points once the store is full; a last flag still starts the run.
      if (fill_count < NUM_POINTS) begin
        store_x[fill_count] = x;
        store_y[fill_count] = y;
        fill_count++;
      end
      points_loaded++;
      if (last_pt) predict_clustering();
    end
  endtask

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Present one item and hold it until the transfer happens. Valid is left
  // high afterwards so a back-to-back item never lowers and raises it in one step.
  task automatic send_item(input bit mode, input logic [15:0] x, input logic [15:0] y,
                           input bit last_pt, input logic [9:0] q);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_point_x <= x;
    in_point_y <= y;
    in_last_point <= last_pt;
    in_query_index <= q;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    absorb_item(mode, x, y, last_pt, q);
  endtask

  task automatic load_point(input logic [15:0] x, input logic [15:0] y, input bit last_pt);
    send_item(MODE_LOAD, x, y, last_pt, 10'($urandom_range(0, 1023)));
  endtask

  // Point fields are don't-care on a read; randomize them anyway.
  task automatic read_label(input logic [9:0] q);
    send_item(MODE_QUERY, 16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)), q);
  endtask

  // Drain every outstanding result, then let the sequencer settle.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_CLUSTERS: reg_clusters = value[4:0];
      CFG_MAX_ITER: reg_max_iter = value[7:0];
      CFG_SEED: begin
        reg_seed = value;
        pick_lfsr = (value == 0) ? 16'd1 : value;
      end
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] k, input logic [15:0] cap,
                           input logic [15:0] sd);
    wait_quiet();
    write_reg(CFG_CLUSTERS, k);
    write_reg(CFG_MAX_ITER, cap);
    write_reg(CFG_SEED, sd);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Corner coordinates under reset config, then read every label back.
  task automatic test_coordinate_extremes();
    load_point(16'h8000, 16'h8000, 1'b0);
    load_point(16'h7FFF, 16'h7FFF, 1'b0);
    load_point(16'h8000, 16'h7FFF, 1'b0);
    load_point(16'h7FFF, 16'h8000, 1'b0);
    load_point(16'h0000, 16'h0000, 1'b1);
    for (int i = 0; i < 5; i++) read_label(10'(i));
  endtask

  // Identical points: every distance ties, so cluster 0 takes all of them and
  // the other clusters stay empty and keep their seeded mean.
  task automatic test_ties_and_empty();
    configure(16'd4, 16'd10, 16'hACE1);
    for (int i = 0; i < 3; i++) load_point(16'h1234, 16'hFEDC, i == 2);
    read_label(10'd1);
  endtask

  // Out-of-range k, zero cap, zero seed, the maximum of each, single point set.
  task automatic test_register_limits();
    configure(16'd0, 16'd0, 16'd0);
    load_point(16'h0100, 16'hFF00, 1'b0);
    load_point(16'hF000, 16'h0010, 1'b1);
    configure(16'd31, 16'd255, 16'hFFFF);
    for (int i = 0; i < 6; i++) load_point(16'($urandom), 16'($urandom), i == 5);
    configure(16'd16, 16'd1, 16'h5A5A);
    load_point(16'h4000, 16'hC000, 1'b1);
    read_label(10'd0);
  endtask

  // Well-formed point sets drawn around a few centers, with label reads mixed in
  // and occasional reconfiguration between sets.
  task automatic test_random_sets();
    int sent, n, centers, spread;
    logic [15:0] cx [4];
    logic [15:0] cy [4];
    int c;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0)
        configure(16'($urandom_range(0, 31)),
                  16'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                      : $urandom_range(1, 20)),
                  16'($urandom_range(0, 65535)));
      gaps_on = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0: n = 1;
        1, 2: n = $urandom_range(13, 40);
        default: n = $urandom_range(2, 12);
      endcase
      centers = $urandom_range(1, 4);
      spread = ($urandom_range(0, 1) != 0) ? 255 : 4095;
      for (int j = 0; j < 4; j++) begin
        cx[j] = 16'($urandom);
        cy[j] = 16'($urandom);
      end
      for (int i = 0; i < n; i++) begin
        if (labeled_upto > 0 && $urandom_range(0, 7) == 0) begin
          read_label(10'($urandom_range(0, labeled_upto - 1)));
          sent++;
        end
        c = $urandom_range(0, centers - 1);
        if ($urandom_range(0, 9) == 0)
          load_point(16'($urandom), 16'($urandom), i == n - 1);
        else
          load_point(cx[c] + 16'($signed($urandom_range(0, 2 * spread)) - spread),
                     cy[c] + 16'($signed($urandom_range(0, 2 * spread)) - spread),
                     i == n - 1);
        sent++;
      end
    end
    gaps_on = 1'b1;
    stalls_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver stall: bursts of random length; no new burst starts while stalls_on is low.
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (stalls_on && $urandom_range(0, 5) == 0) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                    : $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    report_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_kind, out_cluster_index, out_mean_x, out_mean_y, out_member_count,
             out_rounds, out_converged, out_last};
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR %0t: unexpected result kind=%0d cluster=%0d", $realtime,
                   out_kind, out_cluster_index);
      end else begin
        want = pending_reports.pop_front();
        reports_checked++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR %0t: exp kind=%0d idx=%0d mx=%0d my=%0d cnt=%0d rnd=%0d cv=%0d lst=%0d | got kind=%0d idx=%0d mx=%0d my=%0d cnt=%0d rnd=%0d cv=%0d lst=%0d",
                     $realtime, want.kind, want.cluster, $signed(want.mean_x),
                     $signed(want.mean_y), want.members, want.rounds, want.converged,
                     want.last, got.kind, got.cluster, $signed(got.mean_x),
                     $signed(got.mean_y), got.members, got.rounds, got.converged, got.last);
        end
      end
    end
  end

  // Watchdog: any transfer on any channel resets the count.
  int stuck_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("timeout with %0d results outstanding", pending_reports.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    mismatches = 0;
    runs_done = 0;
    points_loaded = 0;
    labels_read = 0;
    reports_checked = 0;
    fill_count = 0;
    labeled_upto = 0;
    reg_clusters = 5'd2;
    reg_max_iter = 8'd64;
    reg_seed = 16'd1;
    pick_lfsr = 16'd1;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    for (int i = 0; i < NUM_POINTS; i++) store_label[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_coordinate_extremes();
    test_ties_and_empty();
    test_register_limits();
    test_random_sets();

    // Drain, then give the sequencer time to show any stray result.
    wait_quiet();
    if (pending_reports.size() != 0) mismatches += pending_reports.size();
    $display("covered %0d clustering runs over %0d point loads and %0d label reads",
             runs_done, points_loaded, labels_read);
    $display("%0d results compared, %0d mismatches", reports_checked, mismatches);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
